// File: rtl/lgt_pkg.sv
// Shared types and constants for the letter group tokenizer.
// Used by lgt_parser, lgt_result_queue, the top level and its checker.
package lgt_pkg;

   localparam int MaxResults = 3;
   localparam int CountWidth = $clog2(MaxResults + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'd0,
      ST_A    = 4'd1,
      ST_C    = 4'd2,
      ST_E    = 4'd3,
      ST_I    = 4'd4,
      ST_S    = 4'd5,
      ST_SC   = 4'd6,
      ST_C3   = 4'd7,
      ST_AE   = 4'd8,
      ST_DIG  = 4'd9
   } parse_state_type;

   typedef enum logic [3:0] {
      G_AU  = 4'd0,
      G_CH  = 4'd1,
      G_EI  = 4'd2,
      G_EU  = 4'd3,
      G_IE  = 4'd4,
      G_ST  = 4'd5,
      G_SCH = 4'd6,
      G_AE  = 4'd7,
      G_AEU = 4'd8,
      G_OE  = 4'd9,
      G_UE  = 4'd10,
      G_SZ  = 4'd11,
      G_ERR = 4'd12
   } group_type;

   localparam logic [3:0] GroupMax = G_ERR;

   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharHash  = 8'h23;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowC  = 8'h63;
   localparam logic [7:0] CharLowE  = 8'h65;
   localparam logic [7:0] CharLowH  = 8'h68;
   localparam logic [7:0] CharLowI  = 8'h69;
   localparam logic [7:0] CharLowS  = 8'h73;
   localparam logic [7:0] CharLowT  = 8'h74;
   localparam logic [7:0] CharLowU  = 8'h75;
   localparam logic [7:0] Utf8Lead  = 8'hC3;
   localparam logic [7:0] Utf8Ae    = 8'hA4;
   localparam logic [7:0] Utf8Oe    = 8'hB6;
   localparam logic [7:0] Utf8Ue    = 8'hBC;
   localparam logic [7:0] Utf8Sz    = 8'h9F;

   typedef struct packed {
      logic       is_group;
      logic [7:0] out_byte;
      logic [3:0] group_code;
   } result_type;

   typedef struct packed {
      logic [CountWidth-1:0]             count;
      result_type [MaxResults-1:0]       results;
   } burst_type;

endpackage

// File: rtl/lgt_parser.sv
// Parse state, held digit and the per-byte decode of the tokenizer.
// Depends on lgt_pkg for state codes, group codes and the burst struct.
module lgt_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           text_byte,
   output lgt_pkg::burst_type   burst
);

   lgt_pkg::parse_state_type state_ff, state_in;
   logic [7:0]               held_ff, held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgt_pkg::ST_IDLE;
         held_ff  <= 8'h00;
      end else if (accept) begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   // Which held-item openers may start a new group after a flush
   localparam logic [15:0] MaskAll = (16'd1 << lgt_pkg::ST_A) | (16'd1 << lgt_pkg::ST_C)
      | (16'd1 << lgt_pkg::ST_E) | (16'd1 << lgt_pkg::ST_I) | (16'd1 << lgt_pkg::ST_S)
      | (16'd1 << lgt_pkg::ST_C3);
   localparam logic [15:0] MaskDig = (16'd1 << lgt_pkg::ST_A) | (16'd1 << lgt_pkg::ST_E)
      | (16'd1 << lgt_pkg::ST_S);

   lgt_pkg::parse_state_type opener;
   logic                     is_digit;

   always_comb begin
      case (text_byte)
         lgt_pkg::CharLowA: opener = lgt_pkg::ST_A;
         lgt_pkg::CharLowC: opener = lgt_pkg::ST_C;
         lgt_pkg::CharLowE: opener = lgt_pkg::ST_E;
         lgt_pkg::CharLowI: opener = lgt_pkg::ST_I;
         lgt_pkg::CharLowS: opener = lgt_pkg::ST_S;
         lgt_pkg::Utf8Lead: opener = lgt_pkg::ST_C3;
         default:           opener = lgt_pkg::ST_IDLE;
      endcase
      is_digit = (text_byte inside {[lgt_pkg::CharZero:lgt_pkg::CharNine]});
   end

   lgt_pkg::result_type [lgt_pkg::MaxResults-1:0] res_v;
   logic [lgt_pkg::CountWidth-1:0]                n_v;
   logic                                          do_follow;
   logic [15:0]                                   mask;

   always_comb begin
      res_v     = '0;
      n_v       = '0;
      do_follow = 1'b0;
      mask      = MaskAll;
      state_in  = lgt_pkg::ST_IDLE;
      held_in   = held_ff;

      case (state_ff)
         lgt_pkg::ST_A: begin
            if (text_byte == lgt_pkg::CharLowU) begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_AU}; n_v = n_v + 1'b1;
            end else begin
               res_v[n_v] = '{1'b0, lgt_pkg::CharLowA, 4'h0}; n_v = n_v + 1'b1;
               do_follow = 1'b1;
            end
         end
         lgt_pkg::ST_C: begin
            if (text_byte == lgt_pkg::CharLowH) begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_CH}; n_v = n_v + 1'b1;
            end else begin
               res_v[n_v] = '{1'b0, lgt_pkg::CharLowC, 4'h0}; n_v = n_v + 1'b1;
               do_follow = 1'b1;
            end
         end
         lgt_pkg::ST_E: begin
            if (text_byte == lgt_pkg::CharLowI) begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_EI}; n_v = n_v + 1'b1;
            end else if (text_byte == lgt_pkg::CharLowU) begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_EU}; n_v = n_v + 1'b1;
            end else begin
               res_v[n_v] = '{1'b0, lgt_pkg::CharLowE, 4'h0}; n_v = n_v + 1'b1;
               do_follow = 1'b1;
            end
         end
         lgt_pkg::ST_I: begin
            if (text_byte == lgt_pkg::CharLowE) begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_IE}; n_v = n_v + 1'b1;
            end else begin
               res_v[n_v] = '{1'b0, lgt_pkg::CharLowI, 4'h0}; n_v = n_v + 1'b1;
               do_follow = 1'b1;
            end
         end
         lgt_pkg::ST_S: begin
            if (text_byte == lgt_pkg::CharLowC) begin
               state_in = lgt_pkg::ST_SC;
            end else if (text_byte == lgt_pkg::CharLowT) begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_ST}; n_v = n_v + 1'b1;
            end else begin
               res_v[n_v] = '{1'b0, lgt_pkg::CharLowS, 4'h0}; n_v = n_v + 1'b1;
               do_follow = 1'b1;
            end
         end
         lgt_pkg::ST_SC: begin
            if (text_byte == lgt_pkg::CharLowH) begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_SCH}; n_v = n_v + 1'b1;
            end else begin
               res_v[n_v] = '{1'b0, lgt_pkg::CharLowS, 4'h0}; n_v = n_v + 1'b1;
               res_v[n_v] = '{1'b0, lgt_pkg::CharLowC, 4'h0}; n_v = n_v + 1'b1;
               do_follow = 1'b1;
               mask = MaskAll & ~(16'd1 << lgt_pkg::ST_C);
            end
         end
         lgt_pkg::ST_C3: begin
            if (text_byte == lgt_pkg::Utf8Ae) begin
               state_in = lgt_pkg::ST_AE;
            end else begin
               res_v[n_v].is_group = 1'b1;
               case (text_byte)
                  lgt_pkg::Utf8Oe: res_v[n_v].group_code = lgt_pkg::G_OE;
                  lgt_pkg::Utf8Ue: res_v[n_v].group_code = lgt_pkg::G_UE;
                  lgt_pkg::Utf8Sz: res_v[n_v].group_code = lgt_pkg::G_SZ;
                  default:         res_v[n_v].group_code = lgt_pkg::G_ERR;
               endcase
               n_v = n_v + 1'b1;
            end
         end
         lgt_pkg::ST_AE: begin
            if (text_byte == lgt_pkg::CharLowU) begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_AEU}; n_v = n_v + 1'b1;
            end else begin
               res_v[n_v] = '{1'b1, 8'h00, lgt_pkg::G_AE}; n_v = n_v + 1'b1;
               do_follow = 1'b1;
               mask = MaskAll & ~(16'd1 << lgt_pkg::ST_I);
            end
         end
         lgt_pkg::ST_DIG: begin
            // Release the held digit one byte late
            res_v[n_v] = '{1'b0, held_ff, 4'h0}; n_v = n_v + 1'b1;
            if (is_digit) begin
               held_in  = text_byte;
               state_in = lgt_pkg::ST_DIG;
            end else begin
               do_follow = 1'b1;
               mask = MaskDig;
            end
         end
         default: begin
            if (is_digit) begin
               res_v[n_v] = '{1'b0, lgt_pkg::CharHash, 4'h0}; n_v = n_v + 1'b1;
               held_in  = text_byte;
               state_in = lgt_pkg::ST_DIG;
            end else begin
               do_follow = 1'b1;
            end
         end
      endcase

      if (do_follow) begin
         if (opener != lgt_pkg::ST_IDLE && mask[opener]) begin
            state_in = opener;
         end else begin
            if (text_byte != lgt_pkg::CharNul) begin
               res_v[n_v] = '{1'b0, text_byte, 4'h0}; n_v = n_v + 1'b1;
            end
            state_in = lgt_pkg::ST_IDLE;
         end
      end

      burst.count   = n_v;
      burst.results = res_v;
   end

endmodule

// File: rtl/lgt_result_queue.sv
// Result register holding the up to three results of one request.
// Depends on lgt_pkg for the result and burst structs.
module lgt_result_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  lgt_pkg::burst_type              burst,
   input  logic                            pop,
   output lgt_pkg::result_type             head,
   output logic [lgt_pkg::CountWidth-1:0]  count
);

   lgt_pkg::result_type [lgt_pkg::MaxResults-1:0] slots_ff, slots_in;
   logic [lgt_pkg::CountWidth-1:0]                count_ff, count_in;

   always_comb begin
      slots_in = slots_ff;
      count_in = count_ff;
      if (pop) begin
         // Advance the queue by one
         for (int i = 0; i < lgt_pkg::MaxResults - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end
      if (load) begin
         slots_in = burst.results;
         count_in = burst.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   assign head  = slots_ff[0];
   assign count = count_ff;

endmodule

// File: rtl/letter_group_tokenizer_unit.sv
// Top level of the letter group tokenizer.
// Instantiates lgt_parser and lgt_result_queue; uses lgt_pkg.
//
// Takes one text byte a cycle while req_stall is low and turns it into zero
// to three results, each a plain byte or a group token, the final one of a
// request marked by rsp_last. A byte with at most one result is followed by
// the next byte every cycle while rsp_stall is low; a byte with more holds
// req_stall until its last result leaves, one per unstalled cycle, from the
// three-entry result register. A byte that yields no result shows nothing.
module letter_group_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_group,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_group_code,
   output logic       rsp_last
);

   lgt_pkg::burst_type             burst;
   lgt_pkg::result_type            head;
   logic [lgt_pkg::CountWidth-1:0] count;
   logic                           accept;
   logic                           pop;

   assign rsp_valid = (count != '0);
   assign pop       = rsp_valid && !rsp_stall;
   // Take a new request when the queue is empty or its final result leaves now
   assign req_stall = !((count == '0) || (count == 1 && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   lgt_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .burst     (burst)
   );

   lgt_result_queue u_queue (
      .clock (clock),
      .reset (reset),
      .load  (accept && burst.count != '0),
      .burst (burst),
      .pop   (pop),
      .head  (head),
      .count (count)
   );

   assign rsp_is_group   = head.is_group;
   assign rsp_out_byte   = head.out_byte;
   assign rsp_group_code = head.group_code;
   assign rsp_last       = (count == 1);

endmodule

// File: rtl/lgt_checker.sv
// Port-level checks for letter_group_tokenizer_unit, attached by bind.
// Depends on lgt_pkg for the highest group code.
module lgt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_group,
   input logic [7:0] rsp_out_byte,
   input logic [3:0] rsp_group_code,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_group_code) && $stable(rsp_is_group) && $stable(rsp_last))
      else $error("stalled result changed");

   a_req_only_at_end: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid || (rsp_last && !rsp_stall))
      else $error("request taken while earlier results pending");

   a_group_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_group |-> rsp_out_byte == 8'h00)
      else $error("group token carries a byte");

   a_plain_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_group |-> rsp_group_code == 4'h0)
      else $error("plain byte carries a group code");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_group_code <= lgt_pkg::GroupMax)
      else $error("group code out of range");

endmodule

bind letter_group_tokenizer_unit lgt_checker u_lgt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_is_group   (rsp_is_group),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_group_code (rsp_group_code),
   .rsp_last       (rsp_last)
);
